// ===== sv/urm_pkg.sv =====
// ----------------------------------------------------------------------------
// urm_pkg
// Shared types and constants of the 16550A-style UART register model.
// ----------------------------------------------------------------------------
package urm_pkg;

   localparam int RX_DEPTH = 64;
   localparam int RX_PTR_W = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   typedef logic [RX_PTR_W-1:0] rx_ptr_type;

   typedef enum logic [1:0] {
      CMD_READ    = 2'd0,
      CMD_WRITE   = 2'd1,
      CMD_HOST_RX = 2'd2
   } cmd_type;

   localparam logic [2:0] REG_RBR_THR = 3'd0;
   localparam logic [2:0] REG_IER     = 3'd1;
   localparam logic [2:0] REG_IIR_FCR = 3'd2;
   localparam logic [2:0] REG_LCR     = 3'd3;
   localparam logic [2:0] REG_MCR     = 3'd4;
   localparam logic [2:0] REG_LSR     = 3'd5;
   localparam logic [2:0] REG_MSR     = 3'd6;
   localparam logic [2:0] REG_SCR     = 3'd7;

   localparam logic [0:0] CSR_MSR_LINES = 1'b0;

   localparam logic [3:0] ACCESS_BYTE  = 4'd1;
   localparam logic [7:0] LCR_EFR_KEY  = 8'hbf;
   localparam logic [7:0] WIDE_READ    = 8'hff;
   localparam logic [7:0] LSR_IDLE     = 8'h60;
   localparam logic [7:0] IIR_NONE     = 8'h01;
   localparam logic [7:0] IIR_RX_DATA  = 8'h04;
   localparam logic [7:0] IIR_THR_EMPTY = 8'h02;
   localparam logic [7:0] IIR_FIFO_ON  = 8'hc0;
   localparam logic [7:0] MSR_RESET    = 8'hb0;

   localparam int LCR_DLAB_BIT = 7;
   localparam int MCR_OUT2_BIT = 3;
   localparam int MCR_LOOP_BIT = 4;

   typedef struct packed {
      logic [1:0] command;
      logic [2:0] offset;
      logic [3:0] access_size;
      logic [7:0] write_data;
   } req_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       tx_valid;
      logic [7:0] tx_data;
      logic       intr_line;
      logic       rx_accepted;
   } rsp_type;

   typedef struct packed {
      logic       wr_en;
      rx_ptr_type wr_addr;
      logic [7:0] wr_data;
      rx_ptr_type rd_addr;
   } ram_ctrl_type;

   function automatic rx_ptr_type ptr_next(input rx_ptr_type p);
      if (p == RX_PTR_W'(RX_DEPTH - 1)) begin
         return '0;
      end
      return p + 1'b1;
   endfunction

endpackage

// ===== sv/urm_ram.sv =====
// ----------------------------------------------------------------------------
// urm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module urm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/urm_regs.sv =====
// ----------------------------------------------------------------------------
// urm_regs
// UART register state, RX ring pointers and single-pass item processing.
// ----------------------------------------------------------------------------
module urm_regs
   import urm_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         advance,
   input  req_type      item,
   input  logic [7:0]   msr_lines,
   input  logic [7:0]   ram_rd_data,
   output ram_ctrl_type ram_ctrl,
   output rsp_type      result
);

   rx_ptr_type wr_ptr_ff, wr_ptr_in;
   rx_ptr_type rd_ptr_ff, rd_ptr_in;
   logic [3:0] ier_ff, ier_in;
   logic [7:0] lcr_ff, lcr_in;
   logic [4:0] mcr_ff, mcr_in;
   logic       fifo_en_ff, fifo_en_in;
   logic [7:0] dll_ff, dll_in;
   logic [7:0] dlm_ff, dlm_in;
   logic [7:0] scr_ff, scr_in;
   logic       thre_ff, thre_in;
   logic       irq_ff, irq_in;
   logic       byp_valid_ff, byp_valid_in;
   logic [7:0] byp_data_ff, byp_data_in;

   logic       dlab;
   logic       loop;
   logic       ring_empty;
   logic       ring_full;
   logic [7:0] rx_head;
   logic [7:0] iir_cur;
   logic [7:0] msr_cur;
   logic       refresh;
   logic       push;
   logic       pend_new;

   assign dlab       = lcr_ff[LCR_DLAB_BIT];
   assign loop       = mcr_ff[MCR_LOOP_BIT];
   assign ring_empty = (wr_ptr_ff == rd_ptr_ff);
   assign ring_full  = (ptr_next(wr_ptr_ff) == rd_ptr_ff);
   assign rx_head    = byp_valid_ff ? byp_data_ff : ram_rd_data;

   always_comb begin
      if (ier_ff[0] && !ring_empty) begin
         iir_cur = IIR_RX_DATA;
      end else if (ier_ff[1] && thre_ff) begin
         iir_cur = IIR_THR_EMPTY;
      end else begin
         iir_cur = IIR_NONE;
      end
      if (fifo_en_ff) begin
         iir_cur = iir_cur | IIR_FIFO_ON;
      end
   end

   always_comb begin
      if (loop) begin
         msr_cur = {mcr_ff[3], mcr_ff[2], mcr_ff[0], mcr_ff[1], 4'd0};
      end else begin
         msr_cur = msr_lines;
      end
   end

   always_comb begin
      wr_ptr_in  = wr_ptr_ff;
      rd_ptr_in  = rd_ptr_ff;
      ier_in     = ier_ff;
      lcr_in     = lcr_ff;
      mcr_in     = mcr_ff;
      fifo_en_in = fifo_en_ff;
      dll_in     = dll_ff;
      dlm_in     = dlm_ff;
      scr_in     = scr_ff;
      thre_in    = thre_ff;
      refresh    = 1'b0;
      push       = 1'b0;
      result     = '0;
      if (advance) begin
         case (item.command)
            CMD_READ: begin
               if (item.access_size != ACCESS_BYTE) begin
                  result.read_data = WIDE_READ;
               end else begin
                  refresh = 1'b1;
                  case (item.offset)
                     REG_RBR_THR: begin
                        if (dlab) begin
                           result.read_data = dll_ff;
                        end else if (!ring_empty) begin
                           result.read_data = rx_head;
                           rd_ptr_in        = ptr_next(rd_ptr_ff);
                        end
                     end
                     REG_IER: begin
                        result.read_data = dlab ? dlm_ff : {4'd0, ier_ff};
                     end
                     REG_IIR_FCR: begin
                        if (lcr_ff != LCR_EFR_KEY) begin
                           result.read_data = iir_cur;
                           if (iir_cur[3:0] == IIR_THR_EMPTY[3:0]) begin
                              thre_in = 1'b0;
                           end
                        end
                     end
                     REG_LCR: result.read_data = lcr_ff;
                     REG_MCR: result.read_data = {3'd0, mcr_ff};
                     REG_LSR: result.read_data = LSR_IDLE | {7'd0, !ring_empty};
                     REG_MSR: result.read_data = msr_cur;
                     default: result.read_data = scr_ff;
                  endcase
               end
            end
            CMD_WRITE: begin
               if (item.access_size == ACCESS_BYTE) begin
                  refresh = 1'b1;
                  case (item.offset)
                     REG_RBR_THR: begin
                        if (dlab) begin
                           dll_in = item.write_data;
                        end else begin
                           if (loop) begin
                              push = !ring_full;
                           end else begin
                              result.tx_valid = 1'b1;
                              result.tx_data  = item.write_data;
                           end
                           thre_in = 1'b1;
                        end
                     end
                     REG_IER: begin
                        if (dlab) begin
                           dlm_in = item.write_data;
                        end else begin
                           if (!ier_ff[1] && item.write_data[1]) begin
                              thre_in = 1'b1;
                           end
                           ier_in = item.write_data[3:0];
                        end
                     end
                     REG_IIR_FCR: begin
                        if (lcr_ff != LCR_EFR_KEY) begin
                           if (item.write_data[1]) begin
                              wr_ptr_in = '0;
                              rd_ptr_in = '0;
                           end
                           fifo_en_in = item.write_data[0];
                        end
                     end
                     REG_LCR: lcr_in = item.write_data;
                     REG_MCR: mcr_in = item.write_data[4:0];
                     REG_SCR: scr_in = item.write_data;
                     default: ;
                  endcase
               end
            end
            CMD_HOST_RX: begin
               refresh            = 1'b1;
               push               = !ring_full;
               result.rx_accepted = !ring_full;
            end
            default: ;
         endcase
      end
      if (push) begin
         wr_ptr_in = ptr_next(wr_ptr_ff);
      end
      pend_new = (ier_in[0] && (wr_ptr_in != rd_ptr_in)) || (ier_in[1] && thre_in);
      irq_in   = refresh ? (pend_new && mcr_in[MCR_OUT2_BIT] && !mcr_in[MCR_LOOP_BIT])
                         : irq_ff;
      result.intr_line = irq_in;
   end

   always_comb begin
      ram_ctrl.wr_en   = push;
      ram_ctrl.wr_addr = wr_ptr_ff;
      ram_ctrl.wr_data = item.write_data;
      ram_ctrl.rd_addr = rd_ptr_in;
      byp_valid_in     = push && (wr_ptr_ff == rd_ptr_in);
      byp_data_in      = item.write_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         ier_ff       <= '0;
         lcr_ff       <= '0;
         mcr_ff       <= '0;
         fifo_en_ff   <= 1'b0;
         dll_ff       <= '0;
         dlm_ff       <= '0;
         scr_ff       <= '0;
         thre_ff      <= 1'b0;
         irq_ff       <= 1'b0;
         byp_valid_ff <= 1'b0;
      end else begin
         wr_ptr_ff    <= wr_ptr_in;
         rd_ptr_ff    <= rd_ptr_in;
         ier_ff       <= ier_in;
         lcr_ff       <= lcr_in;
         mcr_ff       <= mcr_in;
         fifo_en_ff   <= fifo_en_in;
         dll_ff       <= dll_in;
         dlm_ff       <= dlm_in;
         scr_ff       <= scr_in;
         thre_ff      <= thre_in;
         irq_ff       <= irq_in;
         byp_valid_ff <= byp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byp_data_ff <= byp_data_in;
   end

endmodule

// ===== sv/uart_16550_register_model.sv =====
// ----------------------------------------------------------------------------
// uart_16550_register_model
// 16550A-style UART register file with RX ring, DLAB banking and loopback.
// ----------------------------------------------------------------------------
// Usage:
//   req channel carries one item per transfer: a one-byte bus read, a bus
//   write or a byte received from the host line. rsp channel returns exactly
//   one result per item, in order: read data, transmitted byte, interrupt
//   level and RX acceptance.
//   rsp_valid rises once the item has passed the input register and then
//   the result register. One item is taken every cycle while the receiver
//   does not stall; the input register and the result register form a
//   two-stage chain, and the RX ring RAM is read ahead at the read pointer
//   that the item before leaves, with write-to-read bypass.
//   When the receiver stalls, the result register holds and the input
//   register still takes one more item; req_ready drops only when both are
//   full.
//   The APB port holds the MSR value reported outside loopback (addresses 0 to 3);
//   write it only while the block is idle.
//   Synchronous reset empties the ring, clears all UART registers and both
//   stages, and loads the MSR value 0xB0. Ring contents are not cleared.
// ----------------------------------------------------------------------------
module uart_16550_register_model
   import urm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   logic         s1_valid_ff, s1_valid_in;
   req_type      s1_item_ff;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_type      rsp_data_ff;
   logic [7:0]   msr_lines_ff, msr_lines_in;
   logic         advance;
   logic         csr_write;
   rsp_type      result;
   ram_ctrl_type ram_ctrl;
   logic [7:0]   ram_rd_data;

   assign advance   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || advance;

   always_comb begin
      s1_valid_in  = s1_valid_ff;
      rsp_valid_in = rsp_valid_ff;
      if (req_valid && req_ready) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign csr_write = psel && penable && pwrite && pready
                      && (paddr[CSR_ADDR_W-1:2] == CSR_MSR_LINES);
   assign msr_lines_in = csr_write ? pwdata[7:0] : msr_lines_ff;
   assign pready = 1'b1;
   assign prdata = (paddr[CSR_ADDR_W-1:2] == CSR_MSR_LINES)
                   ? {{(CSR_DATA_W-8){1'b0}}, msr_lines_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         msr_lines_ff <= MSR_RESET;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         msr_lines_ff <= msr_lines_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_item_ff <= req_data;
      end
      if (advance) begin
         rsp_data_ff <= result;
      end
   end

   urm_regs u_regs (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .item        (s1_item_ff),
      .msr_lines   (msr_lines_ff),
      .ram_rd_data (ram_rd_data),
      .ram_ctrl    (ram_ctrl),
      .result      (result)
   );

   urm_ram #(
      .WIDTH (8),
      .DEPTH (RX_DEPTH)
   ) u_rx_ram (
      .clock   (clock),
      .wr_en   (ram_ctrl.wr_en),
      .wr_addr (ram_ctrl.wr_addr),
      .wr_data (ram_ctrl.wr_data),
      .rd_addr (ram_ctrl.rd_addr),
      .rd_data (ram_rd_data)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_advance_fills_rsp: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("processed item did not reach the result register");

   a_s1_holds: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !advance |=> s1_valid_ff && $stable(s1_item_ff))
      else $error("stalled item lost from the input register");

   a_tx_rx_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_data_ff.tx_valid && rsp_data_ff.rx_accepted))
      else $error("one result both transmitted and received a byte");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid_ff && !s1_valid_ff)
      else $error("stages not empty after reset");

endmodule
